// File: rtl/htwd_pkg.sv
// shared types and constants of the table walk huffman decoder
// no dependencies; used by htwd_ctrl, htwd_datapath and the top level
`timescale 1ns / 1ps

package htwd_pkg;

    // fixed field widths of the stream transactions
    localparam int ADDR_W    = 9;
    localparam int LEN_W     = 6;
    localparam int CODE_W    = 32;
    localparam int SYMBOL_W  = 12;
    localparam int SYM_MAX_W = 16;

    // s_tdata layout, lowest bit up
    localparam int ADDR_LSB = 0;
    localparam int LEN_LSB  = ADDR_LSB + ADDR_W;
    localparam int CODE_LSB = LEN_LSB + LEN_W;
    localparam int SYM_LSB  = CODE_LSB + CODE_W;
    localparam int BIT_LSB  = SYM_LSB + SYMBOL_W;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 16;

    // s_tuser command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_BIT   = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic write_entry;   // store the incoming codebook entry
        logic take_bit;      // shift in the stream bit, read the current entry
        logic step;          // advance to the next entry and read it
        logic emit;          // load the output register and restart the walk
        logic emit_zero;     // emitted symbol is zero (walk ran off the table)
        logic emit_match;    // emitted with the matched flag set
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic len_lt;        // entry length below accumulated length
        logic len_eq;        // entry length equals accumulated length
        logic code_eq;       // accumulator equals entry codeword
        logic at_last;       // pointer sits on the last table entry
        logic at_max;        // accumulated length reached the code length limit
        logic out_free;      // output register can take a result this cycle
    } dp_status_t;

endpackage

// File: rtl/htwd_ctrl.sv
// walk controller of the table walk huffman decoder
// depends on htwd_pkg for the command and status structs
`timescale 1ns / 1ps

module htwd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  in_command,
    output logic                  in_ready,
    input  htwd_pkg::dp_status_t  status,
    output htwd_pkg::dp_cmd_t     cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_CHECK = 1'b1;

    logic state_reg;
    logic state_next;
    logic emit_now;
    logic len_gt;

    assign in_ready = (state_reg == ST_IDLE);
    assign len_gt   = !status.len_lt && !status.len_eq;

    // any walk outcome that produces a result
    assign emit_now = status.len_lt
                   || (status.len_eq && status.code_eq)
                   || (status.len_eq && !status.code_eq && status.at_last)
                   || (len_gt && status.at_max);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_command == htwd_pkg::CMD_WRITE) begin
                        cmd.write_entry = 1'b1;
                    end else begin
                        cmd.take_bit = 1'b1;
                        state_next   = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (emit_now) begin
                    // hold here until the output register frees up
                    if (status.out_free) begin
                        cmd.emit       = 1'b1;
                        cmd.emit_match = status.len_eq && status.code_eq;
                        cmd.emit_zero  = status.len_eq && !status.code_eq;
                        state_next     = ST_IDLE;
                    end
                end else if (status.len_eq) begin
                    cmd.step = 1'b1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/htwd_datapath.sv
// codebook memory, bit accumulator, entry pointer and output register
// depends on htwd_pkg for field widths and the command and status structs
`timescale 1ns / 1ps

module htwd_datapath #(
    parameter int TABLE_DEPTH  = 512,
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_BITS  = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  htwd_pkg::dp_cmd_t                 cmd,
    output htwd_pkg::dp_status_t              status,
    input  logic [htwd_pkg::ADDR_W-1:0]       wr_address,
    input  logic [htwd_pkg::LEN_W-1:0]        wr_length,
    input  logic [htwd_pkg::CODE_W-1:0]       wr_code,
    input  logic [htwd_pkg::SYMBOL_W-1:0]     wr_symbol,
    input  logic                              stream_bit,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [htwd_pkg::SYMBOL_W-1:0]     out_symbol,
    output logic                              out_matched
);

    localparam int PTR_W = $clog2(TABLE_DEPTH);
    localparam int ALEN_W = $clog2(MAX_CODE_LEN + 1);

    // codebook storage
    logic [htwd_pkg::LEN_W-1:0]  len_mem  [TABLE_DEPTH];
    logic [htwd_pkg::CODE_W-1:0] code_mem [TABLE_DEPTH];
    logic [SYMBOL_BITS-1:0]      sym_mem  [TABLE_DEPTH];

    logic [htwd_pkg::LEN_W-1:0]  rd_len_reg;
    logic [htwd_pkg::CODE_W-1:0] rd_code_reg;
    logic [SYMBOL_BITS-1:0]      rd_sym_reg;

    logic [MAX_CODE_LEN-1:0] acc_reg, acc_next;
    logic [ALEN_W-1:0]       alen_reg, alen_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic                    out_valid_reg, out_valid_next;
    logic [htwd_pkg::SYMBOL_W-1:0] out_symbol_reg;
    logic                    out_matched_reg;

    logic [31:0]                    wr_addr_wide;
    logic                           wr_in_range;
    logic [PTR_W-1:0]               wr_idx;
    logic [htwd_pkg::SYM_MAX_W-1:0] wr_sym_wide;
    logic [htwd_pkg::SYM_MAX_W-1:0] rd_sym_wide;
    logic [PTR_W-1:0]               rd_idx;
    logic                           rd_en;

    assign wr_addr_wide = 32'(wr_address);
    assign wr_in_range  = (wr_addr_wide < 32'(TABLE_DEPTH));
    assign wr_idx       = wr_addr_wide[PTR_W-1:0];
    assign wr_sym_wide  = htwd_pkg::SYM_MAX_W'(wr_symbol);
    assign rd_sym_wide  = htwd_pkg::SYM_MAX_W'(rd_sym_reg);

    assign rd_en  = cmd.take_bit || cmd.step;
    assign rd_idx = cmd.step ? (ptr_reg + 1'b1) : ptr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.write_entry && wr_in_range) begin
            len_mem[wr_idx]  <= wr_length;
            code_mem[wr_idx] <= wr_code;
            sym_mem[wr_idx]  <= wr_sym_wide[SYMBOL_BITS-1:0];
        end
        if (rd_en) begin
            rd_len_reg  <= len_mem[rd_idx];
            rd_code_reg <= code_mem[rd_idx];
            rd_sym_reg  <= sym_mem[rd_idx];
        end
    end

    // walk state
    always_comb begin
        acc_next  = acc_reg;
        alen_next = alen_reg;
        ptr_next  = ptr_reg;
        if (cmd.take_bit) begin
            acc_next  = {acc_reg[MAX_CODE_LEN-2:0], stream_bit};
            alen_next = alen_reg + 1'b1;
        end
        if (cmd.step) begin
            ptr_next = ptr_reg + 1'b1;
        end
        if (cmd.emit) begin
            acc_next  = '0;
            alen_next = '0;
            ptr_next  = '0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            alen_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            alen_reg      <= alen_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_symbol_reg  <= cmd.emit_zero ? '0 : rd_sym_wide[htwd_pkg::SYMBOL_W-1:0];
            out_matched_reg <= cmd.emit_match;
        end
    end

    assign status.len_lt   = (rd_len_reg < htwd_pkg::LEN_W'(alen_reg));
    assign status.len_eq   = (rd_len_reg == htwd_pkg::LEN_W'(alen_reg));
    assign status.code_eq  = (rd_code_reg == htwd_pkg::CODE_W'(acc_reg));
    assign status.at_last  = (ptr_reg == PTR_W'(TABLE_DEPTH - 1));
    assign status.at_max   = (alen_reg == ALEN_W'(MAX_CODE_LEN));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_symbol  = out_symbol_reg;
    assign out_matched = out_matched_reg;

endmodule

// File: rtl/huffman_table_walk_decoder.sv
// top level of the table walk huffman decoder: stream ports and field packing
// depends on htwd_pkg, htwd_ctrl and htwd_datapath
`timescale 1ns / 1ps

// Huffman decoder that walks a codebook sorted by code length. A transaction
// with s_tuser = 0 writes one codebook entry (address, length, codeword,
// symbol) and gives no result. A transaction with s_tuser = 1 shifts one
// stream bit, msb first, into the accumulator and then examines codebook
// entries one per cycle out of a single-port table memory: the entry under
// the pointer, then each further entry of the same length whose codeword did
// not match; when a result is ready it waits for m_tready. s_tready is high
// only between bits. A finished codeword returns its symbol with m_tuser = 1;
// a walk that hits a shorter entry, runs off the table end (symbol 0) or
// reaches MAX_CODE_LEN returns with m_tuser = 0. Each result sits in an
// output register, so the next item is taken while it waits. Entries never
// written read as undefined.

module huffman_table_walk_decoder #(
    parameter int TABLE_DEPTH  = 512,
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_BITS  = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // entry_address, entry_length, entry_code, entry_symbol, stream_bit, zero fill
    input  logic [htwd_pkg::S_DATA_W-1:0]   s_tdata,
    // command
    input  logic                            s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // symbol, zero fill
    output logic [htwd_pkg::M_DATA_W-1:0]   m_tdata,
    // matched
    output logic                            m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready
);

    htwd_pkg::dp_cmd_t    cmd;
    htwd_pkg::dp_status_t status;
    logic [htwd_pkg::SYMBOL_W-1:0] out_symbol;

    // controller owns s_tready; a transaction is taken only in the idle state
    htwd_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_command (s_tuser),
        .in_ready   (s_tready),
        .status     (status),
        .cmd        (cmd)
    );

    // field slicing of s_tdata
    htwd_datapath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_BITS  (SYMBOL_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .wr_address  (s_tdata[htwd_pkg::ADDR_LSB +: htwd_pkg::ADDR_W]),
        .wr_length   (s_tdata[htwd_pkg::LEN_LSB +: htwd_pkg::LEN_W]),
        .wr_code     (s_tdata[htwd_pkg::CODE_LSB +: htwd_pkg::CODE_W]),
        .wr_symbol   (s_tdata[htwd_pkg::SYM_LSB +: htwd_pkg::SYMBOL_W]),
        .stream_bit  (s_tdata[htwd_pkg::BIT_LSB]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_symbol  (out_symbol),
        .out_matched (m_tuser)
    );

    // symbol in the low bits, upper bits zero
    assign m_tdata = htwd_pkg::M_DATA_W'(out_symbol);

endmodule
